### rtl/core/hps_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hps_pkg: shared types and constants of the host power sequencer
// Beat layouts, sequencer state record, phase, kind and status codes.
// ---------------------------------------------------------------------------
package hps_pkg;

  localparam int unsigned KindW    = 3;
  localparam int unsigned FlagsW   = 5;
  localparam int unsigned DurW     = 19;
  localparam int unsigned RailW    = 16;
  localparam int unsigned PollW    = 10;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // Input kinds.
  localparam logic [KindW-1:0] KIND_TICK     = 3'd0;
  localparam logic [KindW-1:0] KIND_BOOT     = 3'd1;
  localparam logic [KindW-1:0] KIND_POWER_ON = 3'd2;
  localparam logic [KindW-1:0] KIND_POWER_OFF = 3'd3;
  localparam logic [KindW-1:0] KIND_SHUTDOWN = 3'd4;

  // Sequencer phases.
  localparam logic [PhaseW-1:0] PH_IDLE       = 3'd0;
  localparam logic [PhaseW-1:0] PH_ON_ASSERT  = 3'd1;
  localparam logic [PhaseW-1:0] PH_ON_WAIT    = 3'd2;
  localparam logic [PhaseW-1:0] PH_OFF_WAIT   = 3'd3;
  localparam logic [PhaseW-1:0] PH_SHUT_GRACE = 3'd4;
  localparam logic [PhaseW-1:0] PH_CUT_WAIT   = 3'd5;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_ALREADY = 2'd1;
  localparam logic [StatusW-1:0] ST_TIMEOUT = 2'd2;
  localparam logic [StatusW-1:0] ST_BUSY    = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_RAIL_WAIT   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_POLL_PERIOD = 1'd1;

  localparam logic [RailW-1:0] RAIL_WAIT_RESET   = 16'd3000;
  localparam logic [PollW-1:0] POLL_PERIOD_RESET = 10'd50;

  // Reset flag bit positions.
  localparam int unsigned FLAG_POR    = 0;
  localparam int unsigned FLAG_LPWAKE = 4;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic              run_level;
    logic [FlagsW-1:0] reset_flags;
    logic [DurW-1:0]   duration_ms;
  } hps_in_t;

  typedef struct packed {
    logic               enable_held;
    logic               busy_res;
    logic               done_res;
    logic [StatusW-1:0] status;
    logic [FlagsW-1:0]  stored_cause;
  } hps_out_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [DurW-1:0]   elapsed_ms;
    logic [PollW-1:0]  poll_count;
    logic [DurW-1:0]   phase_limit;
    logic              hold_flag;
    logic [FlagsW-1:0] cause_bits;
  } hps_state_t;

endpackage

### rtl/core/hps_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hps_step: next-state and result logic of the power sequencer
// Purely combinational; applies one beat to the current sequencer state.
// ---------------------------------------------------------------------------
module hps_step import hps_pkg::*; (
  input  hps_state_t             state_i,
  input  hps_in_t                item_i,
  input  logic [RailW-1:0]       rail_wait_i,
  input  logic [PollW-1:0]       poll_period_i,
  output hps_state_t             state_o,
  output hps_out_t               result_o
);

  typedef struct packed {
    hps_state_t         s;
    logic               fin;
    logic [StatusW-1:0] st;
  } hps_chk_t;

  function automatic hps_state_t enter_phase(hps_state_t s, logic [PhaseW-1:0] ph,
                                             logic [DurW-1:0] limit);
    hps_state_t r;
    r = s;
    r.phase       = ph;
    r.elapsed_ms  = '0;
    r.poll_count  = '0;
    r.phase_limit = limit;
    return r;
  endfunction

  // One check point of a waiting phase.
  function automatic hps_chk_t check_point(hps_state_t s, logic run,
                                           logic [RailW-1:0] rail);
    hps_chk_t r;
    logic     go_on;
    r.s   = s;
    r.fin = 1'b0;
    r.st  = ST_OK;
    go_on = 1'b1;
    if (s.phase == PH_SHUT_GRACE) begin
      if (s.elapsed_ms >= s.phase_limit) begin
        r.s.hold_flag = 1'b1;
        r.s = enter_phase(r.s, PH_CUT_WAIT, {{(DurW-RailW){1'b0}}, rail});
      end else if (!run) begin
        r.s   = enter_phase(r.s, PH_IDLE, '0);
        r.fin = 1'b1;
        r.st  = ST_OK;
        go_on = 1'b0;
      end else begin
        go_on = 1'b0;
      end
    end
    if (go_on && (r.s.phase == PH_ON_WAIT || r.s.phase == PH_OFF_WAIT ||
                  r.s.phase == PH_CUT_WAIT)) begin
      if (r.s.elapsed_ms >= r.s.phase_limit) begin
        r.s   = enter_phase(r.s, PH_IDLE, '0);
        r.fin = 1'b1;
        r.st  = ST_TIMEOUT;
      end else if (run == (r.s.phase == PH_ON_WAIT)) begin
        // After a cut, run going low still ends in a timed-out report.
        r.st  = (r.s.phase == PH_CUT_WAIT) ? ST_TIMEOUT : ST_OK;
        r.s   = enter_phase(r.s, PH_IDLE, '0);
        r.fin = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic hps_chk_t release_and_wait(hps_state_t s, logic run,
                                                logic [RailW-1:0] rail);
    hps_state_t t;
    t = s;
    t.hold_flag = 1'b0;
    t = enter_phase(t, PH_ON_WAIT, {{(DurW-RailW){1'b0}}, rail});
    return check_point(t, run, rail);
  endfunction

  logic [PollW-1:0] poll_len;
  assign poll_len = (poll_period_i == '0) ? PollW'(1) : poll_period_i;

  always_comb begin
    hps_chk_t         c;
    hps_state_t       s;
    logic [DurW:0]    e;
    logic [PollW-1:0] pc;
    logic             fin;
    logic [StatusW-1:0] st;
    logic             run;

    s   = state_i;
    fin = 1'b0;
    st  = ST_OK;
    run = item_i.run_level;
    e   = '0;
    pc  = '0;
    c   = '0;

    unique case (item_i.kind)
      KIND_TICK: begin
        if (s.phase == PH_IDLE) begin
          // Nothing to time.
        end else if (s.phase == PH_ON_ASSERT) begin
          e = {1'b0, s.elapsed_ms} + (DurW+1)'(1);
          s.elapsed_ms = (e > {1'b0, s.phase_limit}) ? s.phase_limit : e[DurW-1:0];
          if (s.elapsed_ms >= s.phase_limit) begin
            c   = release_and_wait(s, run, rail_wait_i);
            s   = c.s;
            fin = c.fin;
            st  = c.st;
          end
        end else if (s.phase > PH_CUT_WAIT) begin
          s = enter_phase(s, PH_IDLE, '0);
        end else begin
          pc = s.poll_count + PollW'(1);
          if (pc < poll_len) begin
            s.poll_count = pc;
          end else begin
            s.poll_count = '0;
            e = {1'b0, s.elapsed_ms} + (DurW+1)'(poll_len);
            s.elapsed_ms = (e > {1'b0, s.phase_limit}) ? s.phase_limit : e[DurW-1:0];
            c   = check_point(s, run, rail_wait_i);
            s   = c.s;
            fin = c.fin;
            st  = c.st;
          end
        end
      end
      KIND_BOOT: begin
        s.cause_bits = item_i.reset_flags;
        s = enter_phase(s, PH_IDLE, '0);
        s.hold_flag = item_i.reset_flags[FLAG_POR] | item_i.reset_flags[FLAG_LPWAKE] | ~run;
      end
      KIND_POWER_ON, KIND_POWER_OFF, KIND_SHUTDOWN: begin
        if (s.phase != PH_IDLE) begin
          fin = 1'b1;
          st  = ST_BUSY;
        end else if (item_i.kind == KIND_POWER_ON) begin
          if (run) begin
            fin = 1'b1;
            st  = ST_ALREADY;
          end else begin
            s.hold_flag = 1'b1;
            s = enter_phase(s, PH_ON_ASSERT, item_i.duration_ms);
            if (item_i.duration_ms == '0) begin
              c   = release_and_wait(s, run, rail_wait_i);
              s   = c.s;
              fin = c.fin;
              st  = c.st;
            end
          end
        end else if (item_i.kind == KIND_POWER_OFF) begin
          s.hold_flag = 1'b1;
          s   = enter_phase(s, PH_OFF_WAIT, {{(DurW-RailW){1'b0}}, rail_wait_i});
          c   = check_point(s, run, rail_wait_i);
          s   = c.s;
          fin = c.fin;
          st  = c.st;
        end else begin
          if (!run) begin
            fin = 1'b1;
            st  = ST_OK;
          end else begin
            s   = enter_phase(s, PH_SHUT_GRACE, item_i.duration_ms);
            c   = check_point(s, run, rail_wait_i);
            s   = c.s;
            fin = c.fin;
            st  = c.st;
          end
        end
      end
      default: begin
        // Unused kinds leave everything as it is.
      end
    endcase

    state_o               = s;
    result_o.enable_held  = s.hold_flag;
    result_o.busy_res     = (s.phase != PH_IDLE);
    result_o.done_res     = fin;
    result_o.status       = fin ? st : ST_OK;
    result_o.stored_cause = s.cause_bits;
  end

endmodule

### rtl/core/host_power_sequencer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// host_power_sequencer_unit: enable-line sequencer for an attached host
// Input beats are 1 ms ticks, boot events and power commands; each beat
// yields exactly one result beat carrying the enable hold and status.
//
// Channels: in_valid_i / in_stall_o / in_data_i carry input beats, and
// out_valid_o / out_stall_i / out_data_o carry result beats. A beat moves on
// a rising edge with valid high and stall low. Configuration writes use
// cfg_valid_i / cfg_ready_o with cfg_index_i (0 rail wait, 1 poll period)
// and cfg_data_i; cfg_ready_o is always high.
// Path: a beat taken is held in the input register, passes the next-state
// logic and is written to the result register once that register is free.
// Throughput: one beat per cycle unless the result side stalls, set by the
// single pass of next-state logic between the input and result registers.
// Reset: the sequencer returns to idle with the enable released, the stored
// cause cleared and the registers at 3000 ms and 50 ms.
// Stall: while the result waits, one more beat is taken into the input
// register; after that in_stall_o rises until the result is taken.
// ---------------------------------------------------------------------------
module host_power_sequencer_unit import hps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hps_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hps_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic             in_valid_q;
  hps_in_t          in_q;
  logic             out_valid_q;
  hps_out_t         out_q;
  hps_state_t       state_q, state_d;
  hps_out_t         result;
  logic [RailW-1:0] rail_wait_q;
  logic [PollW-1:0] poll_period_q;
  logic             out_free;
  logic             advance;
  logic             in_accept;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  hps_step u_step (
    .state_i       (state_q),
    .item_i        (in_q),
    .rail_wait_i   (rail_wait_q),
    .poll_period_i (poll_period_q),
    .state_o       (state_d),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rail_wait_q   <= RAIL_WAIT_RESET;
      poll_period_q <= POLL_PERIOD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_RAIL_WAIT:   rail_wait_q   <= cfg_data_i[RailW-1:0];
        CFG_POLL_PERIOD: poll_period_q <= cfg_data_i[PollW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/hps_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hps_checker: port-level checks for the host power sequencer
// Watches the top-level ports only and is bound to every instance.
// ---------------------------------------------------------------------------
module hps_checker import hps_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input hps_out_t            out_data_o
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // The input side only stalls behind a waiting result.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output register");

  // Status is zero unless a command finished.
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.done_res |-> out_data_o.status == ST_OK)
    else $error("status set without done");

  // A busy rejection leaves the running sequence in place.
  a_busy_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res && out_data_o.status == ST_BUSY
      |-> out_data_o.busy_res)
    else $error("busy rejection ended the sequence");

endmodule

bind host_power_sequencer_unit hps_checker u_hps_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking testbench for host_power_sequencer_unit
// A queue-fed driver offers ticks, boot events and power commands. A clocked
// predictor computes the expected result beat for every accepted input beat.
// A monitor compares each result beat field by field, in order, while both
// sides insert random gaps and the receiver occasionally holds off for a
// long stretch. The timing registers are rewritten between phases.
// ---------------------------------------------------------------------------
module tb_top;
  import hps_pkg::*;

  localparam int          NoResult     = -1;
  localparam int unsigned GapMax       = 13;
  localparam int unsigned HoldOffLen   = 240;
  localparam int unsigned QuietLimit   = 3000;
  localparam int unsigned MaxReported  = 10;
  localparam int unsigned KindUnusedLo = 5;
  localparam int unsigned KindTop      = (1 << KindW) - 1;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  hps_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  hps_out_t            out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  host_power_sequencer_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  hps_in_t     pending_beats[$];
  hps_out_t    expected_results[$];
  int unsigned beats_queued   = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  logic [1:0]  idle_mode      = 2'b00;  // bit 0: sender gaps, bit 1: receiver stalls

  // Shadow of the sequencer state and its timing registers.
  logic [PhaseW-1:0] seq_phase     = PH_IDLE;
  logic [DurW-1:0]   seq_elapsed   = '0;
  logic [PollW-1:0]  seq_polls     = '0;
  logic [DurW-1:0]   seq_limit     = '0;
  logic              seq_hold      = 1'b0;
  logic [FlagsW-1:0] seq_cause     = '0;
  logic [RailW-1:0]  rail_wait_q   = RAIL_WAIT_RESET;
  logic [PollW-1:0]  poll_period_q = POLL_PERIOD_RESET;

  function automatic int unsigned poll_len();
    return (poll_period_q == 0) ? 1 : poll_period_q;
  endfunction

  function automatic void start_phase(input logic [PhaseW-1:0] ph, input int unsigned lim);
    seq_phase   = ph;
    seq_elapsed = '0;
    seq_polls   = '0;
    seq_limit   = lim[DurW-1:0];
  endfunction

  // One look at the run level inside a wait; reaching the limit ends the wait.
  function automatic int check_run(input logic run);
    logic want_high;
    int   ok_code;
    if (seq_phase == PH_SHUT_GRACE) begin
      if (seq_elapsed >= seq_limit) begin
        seq_hold = 1'b1;
        start_phase(PH_CUT_WAIT, 32'(rail_wait_q));
      end else if (!run) begin
        start_phase(PH_IDLE, 0);
        return int'(ST_OK);
      end else begin
        return NoResult;
      end
    end
    if (seq_phase == PH_ON_WAIT || seq_phase == PH_OFF_WAIT || seq_phase == PH_CUT_WAIT) begin
      want_high = (seq_phase == PH_ON_WAIT);
      ok_code   = (seq_phase == PH_CUT_WAIT) ? int'(ST_TIMEOUT) : int'(ST_OK);
      if (seq_elapsed >= seq_limit) begin
        start_phase(PH_IDLE, 0);
        return int'(ST_TIMEOUT);
      end
      if (run == want_high) begin
        start_phase(PH_IDLE, 0);
        return ok_code;
      end
    end
    return NoResult;
  endfunction

  function automatic int release_and_watch(input logic run);
    seq_hold = 1'b0;
    start_phase(PH_ON_WAIT, 32'(rail_wait_q));
    return check_run(run);
  endfunction

  function automatic int tick_step(input logic run);
    int unsigned e;
    if (seq_phase == PH_IDLE) return NoResult;
    if (seq_phase == PH_ON_ASSERT) begin
      e = seq_elapsed + 1;
      seq_elapsed = (e > seq_limit) ? seq_limit : e[DurW-1:0];
      if (seq_elapsed >= seq_limit) return release_and_watch(run);
      return NoResult;
    end
    seq_polls = seq_polls + 1'b1;
    if (seq_polls < poll_len()) return NoResult;
    seq_polls = '0;
    e = seq_elapsed + poll_len();
    seq_elapsed = (e > seq_limit) ? seq_limit : e[DurW-1:0];
    return check_run(run);
  endfunction

  function automatic void sequencer_step(input hps_in_t b);
    int       st;
    hps_out_t r;
    st = NoResult;
    if (b.kind == KIND_TICK) begin
      st = tick_step(b.run_level);
    end else if (b.kind == KIND_BOOT) begin
      seq_cause = b.reset_flags;
      start_phase(PH_IDLE, 0);
      seq_hold = b.reset_flags[FLAG_POR] | b.reset_flags[FLAG_LPWAKE] | !b.run_level;
    end else if (b.kind <= KIND_SHUTDOWN) begin
      if (seq_phase != PH_IDLE) begin
        st = int'(ST_BUSY);
      end else if (b.kind == KIND_POWER_ON) begin
        if (b.run_level) begin
          st = int'(ST_ALREADY);
        end else begin
          seq_hold = 1'b1;
          start_phase(PH_ON_ASSERT, 32'(b.duration_ms));
          if (b.duration_ms == 0) st = release_and_watch(b.run_level);
        end
      end else if (b.kind == KIND_POWER_OFF) begin
        seq_hold = 1'b1;
        start_phase(PH_OFF_WAIT, 32'(rail_wait_q));
        st = check_run(b.run_level);
      end else if (!b.run_level) begin
        st = int'(ST_OK);
      end else begin
        start_phase(PH_SHUT_GRACE, 32'(b.duration_ms));
        st = check_run(b.run_level);
      end
    end
    r.enable_held  = seq_hold;
    r.busy_res     = (seq_phase != PH_IDLE);
    r.done_res     = (st != NoResult);
    r.status       = (st != NoResult) ? st[StatusW-1:0] : ST_OK;
    r.stored_cause = seq_cause;
    expected_results.push_back(r);
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReported) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_result(input hps_out_t got);
    hps_out_t want;
    if (expected_results.size() == 0) begin
      log_mismatch($sformatf("result beat %h arrived with nothing expected", got));
    end else begin
      want = expected_results.pop_front();
      if (got.enable_held !== want.enable_held || got.busy_res !== want.busy_res ||
          got.done_res !== want.done_res || got.status !== want.status ||
          got.stored_cause !== want.stored_cause)
        log_mismatch($sformatf(
          "expected hold %b busy %b done %b status %0d cause %h, got %b %b %b %0d %h",
          want.enable_held, want.busy_res, want.done_res, want.status, want.stored_cause,
          got.enable_held, got.busy_res, got.done_res, got.status, got.stored_cause));
    end
  endfunction

  // Driver: the gap before the next beat is drawn when a beat is taken.
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    logic nxt_valid;
    if (rst_ni) begin
      nxt_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        sequencer_step(in_data_i);
        nxt_valid = 1'b0;
        send_gap  = idle_mode[0] ? $urandom_range(0, GapMax) : 0;
      end
      if (!nxt_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_beats.size() != 0) begin
          in_data_i <= pending_beats.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // Monitor: random stalls per beat, plus a long hold-off while the sender
  // still has plenty queued, so that the block fills up and stalls its input.
  int unsigned recv_wait     = 0;
  int unsigned hold_left     = 0;
  int unsigned pressure_runs = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_result(out_data_o);
        recv_wait = idle_mode[1] ? $urandom_range(0, GapMax) : 0;
        if (pressure_runs < 2 && pending_beats.size() > 60) begin
          hold_left = HoldOffLen;
          pressure_runs++;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (recv_wait != 0) begin
        recv_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("host_power_sequencer_unit verification failed");
      $finish;
    end
  end

  function automatic int unsigned rand_dur();
    return $urandom_range(0, (1 << DurW) - 1);
  endfunction

  function automatic void queue_beat(input int unsigned kind, input int unsigned run,
                                     input int unsigned flags, input int unsigned dur);
    hps_in_t b;
    b.kind        = kind[KindW-1:0];
    b.run_level   = run[0];
    b.reset_flags = flags[FlagsW-1:0];
    b.duration_ms = dur[DurW-1:0];
    pending_beats.push_back(b);
    if (kind <= KIND_SHUTDOWN) beats_queued++;
  endfunction

  // Mostly a command followed by a random run of ticks, with a few other beats
  // mixed in and the run level changing at most once; the rest is loose noise.
  function automatic void queue_sequence();
    int unsigned pick, span, n, flip_at, d_eff, cmd, dur;
    logic        run0;
    pick = $urandom_range(0, 99);
    if (pick >= 75) begin
      queue_beat($urandom_range(0, KindTop), $urandom_range(0, 1), $urandom_range(0, 31),
                 rand_dur());
      return;
    end
    cmd  = $urandom_range(KIND_POWER_ON, KIND_SHUTDOWN);
    run0 = (cmd != KIND_POWER_ON);
    if ($urandom_range(0, 9) == 0) run0 = !run0;
    dur = ($urandom_range(0, 11) == 0) ? rand_dur() : $urandom_range(0, 12);
    queue_beat(cmd, run0, $urandom_range(0, 31), dur);
    d_eff = (dur > 150) ? 150 : dur;
    span  = d_eff + rail_wait_q + 3 * poll_len() + 4;
    if (span > 150) span = 150;
    n       = $urandom_range(0, span);
    flip_at = $urandom_range(0, n);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)
        queue_beat($urandom_range(KIND_POWER_ON, KIND_SHUTDOWN), $urandom_range(0, 1),
                   $urandom_range(0, 31), $urandom_range(0, 12));
      else if (pick < 6)
        queue_beat(KIND_BOOT, $urandom_range(0, 1), $urandom_range(0, 31), rand_dur());
      else if (pick < 8)
        queue_beat($urandom_range(KindUnusedLo, KindTop), $urandom_range(0, 1),
                   $urandom_range(0, 31), rand_dur());
      else
        queue_beat(KIND_TICK, (i < flip_at) ? run0 : !run0, $urandom_range(0, 31),
                   rand_dur());
    end
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CfgDataW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_RAIL_WAIT) rail_wait_q = val[RailW-1:0];
    else poll_period_q = val[PollW-1:0];
    cfg_valid_i <= 1'b0;
  endtask

  // Lets the queue empty and every expected beat arrive, then a short pause.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_random_phase(input int unsigned rail, input int unsigned poll);
    int unsigned goal;
    write_reg(CFG_RAIL_WAIT, rail);
    write_reg(CFG_POLL_PERIOD, poll);
    @(negedge clk_i);
    idle_mode    = 2'($urandom_range(0, 3));
    goal         = (rail > 200 || poll > 50) ? 60 : 190;
    beats_queued = 0;
    while (beats_queued < goal) queue_sequence();
    wait_drained();
  endtask

  initial begin : stimulus
    static int unsigned rails[12] = '{1, 7, 65535, 20, 0, 40, 12, 3, 30, 65535, 9, 25};
    static int unsigned polls[12] = '{1, 3, 1000, 0, 2, 5, 1023, 1, 4, 1, 2, 0};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // After reset: boot causes, already on, shutdown with run low, unused
    // kinds, a command while busy and a boot that aborts a sequence.
    @(negedge clk_i);
    idle_mode = 2'b11;
    queue_beat(KIND_TICK, 0, 0, 0);
    queue_beat(KIND_BOOT, 1, 5'b00001, 0);
    queue_beat(KIND_BOOT, 1, 5'b10000, 0);
    queue_beat(KIND_BOOT, 1, 5'b00110, 0);
    queue_beat(KIND_BOOT, 0, 5'b01000, 0);
    queue_beat(KIND_POWER_ON, 1, 0, 7);
    queue_beat(KIND_SHUTDOWN, 0, 0, 7);
    for (int k = KindUnusedLo; k <= KindTop; k++) queue_beat(k, 1, 31, (1 << DurW) - 1);
    queue_beat(KIND_POWER_ON, 0, 0, (1 << DurW) - 1);
    queue_beat(KIND_POWER_OFF, 0, 0, 0);
    queue_beat(KIND_SHUTDOWN, 1, 0, 0);
    queue_beat(KIND_BOOT, 1, 31, 0);
    wait_drained();

    // Zero rail wait and zero poll period: rail waits end at once.
    write_reg(CFG_RAIL_WAIT, 0);
    write_reg(CFG_POLL_PERIOD, 0);
    @(negedge clk_i);
    queue_beat(KIND_POWER_ON, 0, 0, 0);
    queue_beat(KIND_POWER_OFF, 1, 0, 0);
    queue_beat(KIND_SHUTDOWN, 1, 0, 0);
    queue_beat(KIND_SHUTDOWN, 1, 0, 3);
    repeat (3) queue_beat(KIND_TICK, 1, 0, 0);
    wait_drained();

    // A rail wait change in the middle of a wait must not affect it.
    write_reg(CFG_RAIL_WAIT, 4);
    write_reg(CFG_POLL_PERIOD, 2);
    @(negedge clk_i);
    queue_beat(KIND_POWER_OFF, 1, 0, 0);
    repeat (2) queue_beat(KIND_TICK, 1, 0, 0);
    wait_drained();
    write_reg(CFG_RAIL_WAIT, 1);
    @(negedge clk_i);
    queue_beat(KIND_TICK, 1, 0, 0);
    queue_beat(KIND_TICK, 0, 0, 0);
    queue_beat(KIND_POWER_ON, 0, 0, 1);
    queue_beat(KIND_TICK, 1, 0, 0);
    wait_drained();

    for (int p = 0; p < 12; p++) run_random_phase(rails[p], polls[p]);

    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("host_power_sequencer_unit verification clean");
    else
      $display("host_power_sequencer_unit verification failed");
    $finish;
  end

endmodule
